### src/srrw_pkg.sv
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types, codes and constants of the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int WINDOW_SLOTS_DEF = 31;
  localparam int MAX_PAYLOAD_DEF  = 512;

  localparam int KIND_W   = 2;
  localparam int SEQ_W    = 8;
  localparam int LEN_W    = 10;
  localparam int HANDLE_W = 10;
  localparam int SLOT_W   = 5;
  localparam int SLOT_MAX = 31;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRUNC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONDATA = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD     = 2'd3;

  localparam logic [KIND_W-1:0] OUT_ACK     = 2'd0;
  localparam logic [KIND_W-1:0] OUT_NACK    = 2'd1;
  localparam logic [KIND_W-1:0] OUT_DELIVER = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SEQ_W-1:0]    seq_num;
    logic [LEN_W-1:0]    payload_len;
    logic [HANDLE_W-1:0] packet_handle;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   out_kind;
    logic [SEQ_W-1:0]    reply_seq;
    logic [SLOT_W-1:0]   free_slots;
    logic [HANDLE_W-1:0] deliver_handle;
    logic [LEN_W-1:0]    deliver_len;
    logic                end_of_transfer;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic                is_nack;
    logic [SEQ_W-1:0]    seq_num;
    logic [LEN_W-1:0]    payload_len;
    logic [HANDLE_W-1:0] packet_handle;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  typedef struct packed {
    logic [SLOT_MAX-1:0] slot_full;
    logic [SLOT_W-1:0]   free_count;
    logic                done;
  } back_status_t;

endpackage

### src/srrw_front.sv
// ----------------------------------------------------------------------------
// srrw_front
// Accepts packet descriptors and filters out non-data, failed and oversized
// packets; data and truncated headers are pushed to the command queue.
// ----------------------------------------------------------------------------
module srrw_front #(
  parameter int MAX_PAYLOAD = srrw_pkg::MAX_PAYLOAD_DEF
) (
  input  logic               start,
  input  logic               busy,
  input  srrw_pkg::in_item_t in_item,
  output srrw_pkg::q_wr_t    q_wr
);
  import srrw_pkg::*;

  logic is_data;
  logic len_ok;

  always_comb begin
    is_data = in_item.kind inside {KIND_FULL, KIND_TRUNC};
    len_ok  = in_item.payload_len <= LEN_W'(MAX_PAYLOAD);
    q_wr.valid             = start & ~busy & is_data & len_ok;
    q_wr.cmd.is_nack       = (in_item.kind == KIND_TRUNC);
    q_wr.cmd.seq_num       = in_item.seq_num;
    q_wr.cmd.payload_len   = in_item.payload_len;
    q_wr.cmd.packet_handle = in_item.packet_handle;
  end

endmodule

### src/srrw_queue.sv
// ----------------------------------------------------------------------------
// srrw_queue
// Short command queue between the classifier and the window engine.
// ----------------------------------------------------------------------------
module srrw_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  srrw_pkg::q_wr_t q_wr,
  input  logic            pop,
  output srrw_pkg::q_rd_t q_rd,
  output logic            full
);
  import srrw_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_pop;

  always_comb begin
    full        = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
    q_rd.valid  = (count_r != '0);
    q_rd.cmd    = entry_r[rd_ptr_r];
    do_pop      = pop & q_rd.valid;
    wr_ptr_nxt  = q_wr.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt  = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt   = count_r;
    if (q_wr.valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_wr.valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.valid) begin
      entry_r[wr_ptr_r] <= q_wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/srrw_back.sv
// ----------------------------------------------------------------------------
// srrw_back
// Window engine: window check, slot store, in-order run scan, ACK/NACK
// replies and in-order release from the slot ring.
// ----------------------------------------------------------------------------
module srrw_back #(
  parameter int WINDOW_SLOTS = srrw_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  srrw_pkg::q_rd_t        q_rd,
  output logic                   pop,
  output logic                   out_valid,
  output srrw_pkg::out_item_t    out_item,
  output srrw_pkg::back_status_t status
);
  import srrw_pkg::*;

  localparam int DATA_W = HANDLE_W + LEN_W;
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_DELIVER = 2'd2;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);
  localparam logic [SLOT_W-1:0] NUM_SLOTS = SLOT_W'(WINDOW_SLOTS);

  logic [1:0]              state_r, state_nxt;
  logic [SEQ_W-1:0]        next_exp_r, next_exp_nxt;
  logic [SLOT_W-1:0]       head_r, head_nxt;
  logic [SLOT_W-1:0]       free_r, free_nxt;
  logic [WINDOW_SLOTS-1:0] full_r, full_nxt;
  logic                    done_r, done_nxt;
  logic [SLOT_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [SLOT_W-1:0]       run_r, run_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_r, out_nxt;

  logic [DATA_W-1:0]       mem [WINDOW_SLOTS];
  logic [DATA_W-1:0]       rd_data_r;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_wa;

  logic [SEQ_W-1:0]        seq_gap;
  logic                    in_win;
  logic [SLOT_W:0]         slot_sum;
  logic [SLOT_W-1:0]       slot;
  logic [HANDLE_W-1:0]     rd_handle;
  logic [LEN_W-1:0]        rd_len;
  logic                    len_zero;
  logic                    dlv_last;

  always_comb begin
    seq_gap   = q_rd.cmd.seq_num - next_exp_r;
    in_win    = seq_gap < SEQ_W'(WINDOW_SLOTS);
    slot_sum  = {1'b0, head_r} + {1'b0, seq_gap[SLOT_W-1:0]};
    slot      = (slot_sum >= (SLOT_W+1)'(WINDOW_SLOTS))
                ? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_SLOTS)) : slot_sum[SLOT_W-1:0];
    rd_handle = rd_data_r[DATA_W-1:LEN_W];
    rd_len    = rd_data_r[LEN_W-1:0];
    len_zero  = (rd_len == '0);
    dlv_last  = len_zero || (run_r == SLOT_W'(1));

    state_nxt     = state_r;
    next_exp_nxt  = next_exp_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    full_nxt      = full_r;
    done_nxt      = done_r;
    scan_idx_nxt  = scan_idx_r;
    run_nxt       = run_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = slot;

    case (state_r)
      ST_IDLE: begin
        if (q_rd.valid) begin
          pop = 1'b1;
          if (!done_r && in_win) begin
            if (q_rd.cmd.is_nack) begin
              out_valid_nxt     = 1'b1;
              out_nxt.out_kind  = OUT_NACK;
              out_nxt.reply_seq = q_rd.cmd.seq_num;
              out_nxt.free_slots = free_r;
              out_nxt.last      = 1'b1;
            end else begin
              if (!full_r[slot]) begin
                full_nxt[slot] = 1'b1;
                mem_we         = 1'b1;
                if (free_r != '0) begin
                  free_nxt = free_r - 1'b1;
                end
              end
              scan_idx_nxt = head_r;
              run_nxt      = '0;
              state_nxt    = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (full_r[scan_idx_r] && run_r != NUM_SLOTS) begin
          run_nxt      = run_r + 1'b1;
          scan_idx_nxt = (scan_idx_r == LAST_SLOT) ? '0 : scan_idx_r + 1'b1;
        end else begin
          out_valid_nxt      = 1'b1;
          out_nxt.out_kind   = OUT_ACK;
          out_nxt.reply_seq  = next_exp_r + SEQ_W'(run_r);
          out_nxt.free_slots = free_r;
          out_nxt.last       = (run_r == '0);
          state_nxt          = (run_r == '0) ? ST_IDLE : ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        out_valid_nxt          = 1'b1;
        out_nxt.out_kind       = OUT_DELIVER;
        out_nxt.deliver_handle = rd_handle;
        out_nxt.deliver_len    = rd_len;
        out_nxt.end_of_transfer = len_zero;
        out_nxt.last           = dlv_last;
        full_nxt[head_r]       = 1'b0;
        head_nxt               = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
        next_exp_nxt           = next_exp_r + 1'b1;
        if (free_r < NUM_SLOTS) begin
          free_nxt = free_r + 1'b1;
        end
        run_nxt = run_r - 1'b1;
        if (len_zero) begin
          done_nxt = 1'b1;
        end
        if (dlv_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    status.slot_full                   = '0;
    status.slot_full[WINDOW_SLOTS-1:0] = full_r;
    status.free_count                  = free_r;
    status.done                        = done_r;
  end

  // slot store, read port follows the ring head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= {q_rd.cmd.packet_handle, q_rd.cmd.payload_len};
    end
    rd_data_r <= mem[head_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_exp_r  <= '0;
      head_r      <= '0;
      free_r      <= NUM_SLOTS;
      full_r      <= '0;
      done_r      <= 1'b0;
      scan_idx_r  <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_exp_r  <= next_exp_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      full_r      <= full_nxt;
      done_r      <= done_nxt;
      scan_idx_r  <= scan_idx_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### src/selective_repeat_receive_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receiver side of selective-repeat ARQ with 8-bit sequence numbers.
// ----------------------------------------------------------------------------
// A descriptor is taken whenever start is high and busy is low; busy rises
// only while the two-entry command queue is full. Results leave one per cycle
// on out_valid and cannot be held off. Per descriptor the window engine
// either ignores the packet or replies with a NACK; for a data packet it
// stores the packet in its slot if new, scans the slot ring for the
// in-order run (one slot a cycle) and releases the run, the in-order
// packets now held. Non-data, failed and oversized descriptors are
// dropped at the input and never reach the queue.
module selective_repeat_receive_window #(
  parameter int WINDOW_SLOTS = srrw_pkg::WINDOW_SLOTS_DEF,
  parameter int MAX_PAYLOAD  = srrw_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  srrw_pkg::in_item_t  in_item,
  output logic                out_valid,
  output srrw_pkg::out_item_t out_item
);
  import srrw_pkg::*;

  q_wr_t        q_wr;
  q_rd_t        q_rd;
  logic         pop;
  logic         q_full;
  back_status_t status;

  srrw_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_wr    (q_wr)
  );

  srrw_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (pop),
    .q_rd  (q_rd),
    .full  (q_full)
  );

  srrw_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item),
    .status    (status)
  );

  assign busy = q_full;

  // occupied slots and free count always add up to the window
  a_slot_count: assert property (@(posedge clk) disable iff (!rst_n)
    (SLOT_W+1)'($countones(status.slot_full)) + {1'b0, status.free_count}
      == (SLOT_W+1)'(WINDOW_SLOTS))
    else $error("slot occupancy and free count disagree");

  // silent once the transfer has ended
  a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    $past(status.done) |-> !out_valid)
    else $error("result after end of transfer");

  // an end-of-transfer delivery closes the transaction
  a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.end_of_transfer |-> out_item.last)
    else $error("end of transfer not marked last");

endmodule

### dv/selective_repeat_receive_window_check.sv
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_check
// Watches both channels of the receive window, predicts the ACK, NACK and
// delivery results of every accepted packet descriptor and compares each
// result field by field with the oldest one still expected.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  srrw_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  srrw_pkg::out_item_t out_item,
  output int                  fails,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import srrw_pkg::*;

  logic [SEQ_W-1:0]    nxt_seq;
  int                  head_slot;
  int                  free_cnt;
  logic                slot_used [WINDOW_SLOTS_DEF];
  logic [HANDLE_W-1:0] slot_hdl [WINDOW_SLOTS_DEF];
  logic [LEN_W-1:0]    slot_len [WINDOW_SLOTS_DEF];
  logic                xfer_done;

  out_item_t expected_replies [$];
  out_item_t want;
  int        errs;

  task automatic apply_packet(input in_item_t pkt);
    logic [SEQ_W-1:0] seq_gap;
    int               slot;
    int               run;
    int               i;
    bit               going;
    out_item_t        r;
    if (xfer_done || pkt.kind == KIND_NONDATA || pkt.kind == KIND_BAD ||
        pkt.payload_len > MAX_PAYLOAD_DEF) begin
      return;
    end
    seq_gap = pkt.seq_num - nxt_seq;
    if (seq_gap >= WINDOW_SLOTS_DEF) begin
      return;
    end
    r = '0;
    if (pkt.kind == KIND_TRUNC) begin
      r.out_kind   = OUT_NACK;
      r.reply_seq  = pkt.seq_num;
      r.free_slots = free_cnt[SLOT_W-1:0];
      r.last       = 1'b1;
      expected_replies.push_back(r);
      return;
    end
    // a duplicate keeps what is stored and uses no slot
    slot = (head_slot + seq_gap) % WINDOW_SLOTS_DEF;
    if (!slot_used[slot]) begin
      slot_used[slot] = 1'b1;
      slot_hdl[slot]  = pkt.packet_handle;
      slot_len[slot]  = pkt.payload_len;
      if (free_cnt > 0) free_cnt--;
    end
    run   = 0;
    going = 1'b1;
    for (i = 0; i < WINDOW_SLOTS_DEF; i++) begin
      if (going && slot_used[(head_slot + i) % WINDOW_SLOTS_DEF]) run++;
      else going = 1'b0;
    end
    r.out_kind   = OUT_ACK;
    r.reply_seq  = nxt_seq + run[SEQ_W-1:0];
    r.free_slots = free_cnt[SLOT_W-1:0];
    going = 1'b1;
    while (going && slot_used[head_slot]) begin
      expected_replies.push_back(r);
      r = '0;
      r.out_kind        = OUT_DELIVER;
      r.deliver_handle  = slot_hdl[head_slot];
      r.deliver_len     = slot_len[head_slot];
      r.end_of_transfer = (slot_len[head_slot] == '0);
      slot_used[head_slot] = 1'b0;
      head_slot = (head_slot + 1) % WINDOW_SLOTS_DEF;
      nxt_seq   = nxt_seq + 1'b1;
      if (free_cnt < WINDOW_SLOTS_DEF) free_cnt++;
      // zero length ends the transfer and stops the release
      if (r.end_of_transfer) begin
        xfer_done = 1'b1;
        going     = 1'b0;
      end
    end
    r.last = 1'b1;
    expected_replies.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      nxt_seq   = '0;
      head_slot = 0;
      free_cnt  = WINDOW_SLOTS_DEF;
      xfer_done = 1'b0;
      for (int k = 0; k < WINDOW_SLOTS_DEF; k++) begin
        slot_used[k] = 1'b0;
        slot_hdl[k]  = '0;
        slot_len[k]  = '0;
      end
      expected_replies.delete();
      fails   <= 0;
      pending <= 0;
    end else begin
      errs = 0;
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $error("result with nothing expected, out_kind %0d", out_item.out_kind);
          errs++;
        end else begin
          want = expected_replies.pop_front();
          if (out_item.out_kind !== want.out_kind) begin
            $error("out_kind expected %0d got %0d", want.out_kind, out_item.out_kind);
            errs++;
          end
          if (out_item.reply_seq !== want.reply_seq) begin
            $error("reply_seq expected %0d got %0d", want.reply_seq, out_item.reply_seq);
            errs++;
          end
          if (out_item.free_slots !== want.free_slots) begin
            $error("free_slots expected %0d got %0d", want.free_slots, out_item.free_slots);
            errs++;
          end
          if (out_item.deliver_handle !== want.deliver_handle) begin
            $error("deliver_handle expected %0d got %0d", want.deliver_handle,
                   out_item.deliver_handle);
            errs++;
          end
          if (out_item.deliver_len !== want.deliver_len) begin
            $error("deliver_len expected %0d got %0d", want.deliver_len, out_item.deliver_len);
            errs++;
          end
          if (out_item.end_of_transfer !== want.end_of_transfer) begin
            $error("end_of_transfer expected %0d got %0d", want.end_of_transfer,
                   out_item.end_of_transfer);
            errs++;
          end
          if (out_item.last !== want.last) begin
            $error("last expected %0d got %0d", want.last, out_item.last);
            errs++;
          end
        end
      end
      if (start && !busy) apply_packet(in_item);
      fails   <= fails + errs;
      pending <= expected_replies.size();
    end
  end

endmodule

### dv/selective_repeat_receive_window_test.sv
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_test
// Drives packet descriptors into the receive window: a directed pass over
// the window edges, duplicates, truncated and dropped packets, then random
// bursts of reordered data with noise mixed in, and a closing end of
// transfer. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srrw_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 200;
  localparam int RAND_ITEMS  = 200;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  int        fails;
  int        pending;
  int        cycles = 0;
  bit        quiet;
  logic [SEQ_W-1:0] base;

  selective_repeat_receive_window i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  selective_repeat_receive_window_check i_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .fails    (fails),
    .pending  (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // one transaction: optional gap, then hold start until accepted
  task automatic send_pkt(input logic [KIND_W-1:0] k, input logic [SEQ_W-1:0] s,
                          input int len, input int hdl);
    in_item_t p;
    int       gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    p.kind          = k;
    p.seq_num       = s;
    p.payload_len   = len[LEN_W-1:0];
    p.packet_handle = hdl[HANDLE_W-1:0];
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int n;
    int i;
    int j;
    int tmp;
    int sent;
    int burst_no;
    int order [WINDOW_SLOTS_DEF];
    start   <= 1'b0;
    in_item <= '0;
    rst_n   <= 1'b0;
    quiet   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: drops, window edges, duplicate, gap fill
    send_pkt(KIND_BAD, 8'd0, 5, 1);
    send_pkt(KIND_NONDATA, 8'd0, 5, 2);
    send_pkt(KIND_FULL, 8'd0, 513, 3);
    send_pkt(KIND_FULL, 8'd31, 7, 4);
    send_pkt(KIND_FULL, 8'd255, 7, 5);
    send_pkt(KIND_TRUNC, 8'd0, 0, 6);
    send_pkt(KIND_TRUNC, 8'd30, 512, 7);
    send_pkt(KIND_TRUNC, 8'd31, 9, 8);
    send_pkt(KIND_FULL, 8'd0, 512, 1023);
    send_pkt(KIND_FULL, 8'd3, 1, 0);
    send_pkt(KIND_FULL, 8'd3, 100, 555);
    send_pkt(KIND_TRUNC, 8'd2, 40, 9);
    send_pkt(KIND_FULL, 8'd2, 341, 682);
    send_pkt(KIND_FULL, 8'd1, 170, 341);
    send_pkt(KIND_FULL, 8'd0, 60, 10);
    send_pkt(KIND_TRUNC, 8'd34, 1, 11);
    send_pkt(KIND_TRUNC, 8'd5, 1023, 12);
    base = 8'd4;

    // random bursts of reordered data with noise
    sent     = 0;
    burst_no = 0;
    while (sent < RAND_ITEMS) begin
      if (burst_no == 1) n = WINDOW_SLOTS_DEF;
      else if ($urandom_range(0, 5) == 0) n = $urandom_range(9, WINDOW_SLOTS_DEF);
      else n = $urandom_range(1, 8);
      quiet = ($urandom_range(0, 3) == 0);
      for (i = 0; i < n; i++) order[i] = i;
      if ($urandom_range(0, 3) != 0) begin
        for (i = n - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
      end
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 4))
            0: begin
              send_pkt(KIND_TRUNC, SEQ_W'(base + $urandom_range(0, 30)),
                       $urandom_range(0, 512), $urandom_range(0, 1023));
              sent++;
            end
            1: send_pkt(KIND_W'($urandom_range(0, 3)), SEQ_W'(base + $urandom_range(62, 255)),
                        $urandom_range(0, 1023), $urandom_range(0, 1023));
            2: send_pkt(KIND_W'($urandom_range(KIND_NONDATA, KIND_BAD)),
                        SEQ_W'(base + $urandom_range(0, 30)),
                        $urandom_range(0, 1023), $urandom_range(0, 1023));
            3: send_pkt(KIND_W'($urandom_range(KIND_FULL, KIND_TRUNC)),
                        SEQ_W'(base + $urandom_range(0, 30)),
                        $urandom_range(513, 1023), $urandom_range(0, 1023));
            default: begin
              send_pkt(KIND_FULL, SEQ_W'(base + order[$urandom_range(0, i)]),
                       $urandom_range(1, 512), $urandom_range(0, 1023));
              sent++;
            end
          endcase
        end
        send_pkt(KIND_FULL, SEQ_W'(base + order[i]), $urandom_range(1, 512),
                 $urandom_range(0, 1023));
        sent++;
      end
      base = SEQ_W'(base + n);
      if (burst_no == 3) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      burst_no++;
    end

    // end of transfer: release stops after the empty packet, then silence
    quiet = 1'b0;
    send_pkt(KIND_FULL, SEQ_W'(base + 1), 0, $urandom_range(0, 1023));
    send_pkt(KIND_FULL, SEQ_W'(base + 2), $urandom_range(1, 512), $urandom_range(0, 1023));
    send_pkt(KIND_FULL, base, $urandom_range(1, 512), $urandom_range(0, 1023));
    send_pkt(KIND_FULL, SEQ_W'(base + 2), $urandom_range(1, 512), $urandom_range(0, 1023));
    send_pkt(KIND_TRUNC, SEQ_W'(base + 3), $urandom_range(1, 512), $urandom_range(0, 1023));
    send_pkt(KIND_FULL, SEQ_W'(base + 3), $urandom_range(1, 512), $urandom_range(0, 1023));
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
